>>> hdl/pidsc_pkg.sv
// ----------------------------------------------------------------------------
// pidsc_pkg
// Shared types and constants for the PID speed controller.
// ----------------------------------------------------------------------------
package pidsc_pkg;

  localparam int SPEED_W  = 32;
  localparam int GAIN_W   = 24;
  localparam int RATE_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int VOLT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // shared multiplier: signed 33 x signed 25
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DERIV_W = 49;
  localparam int TERM_W  = 64;
  localparam int ACC_W   = 88;

  localparam logic [GAIN_W-1:0]  KP_RST     = 24'd83060;
  localparam logic [GAIN_W-1:0]  KI_RST     = 24'd52522;
  localparam logic [GAIN_W-1:0]  KD_RST     = 24'd3131;
  localparam logic [GAIN_W-1:0]  PERIOD_RST = 24'd16777;
  localparam logic [RATE_W-1:0]  RATE_RST   = 16'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 15'd14336;
  localparam logic [VOLT_W-1:0]  FLOOR_RST  = 16'hE000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_PERIOD = 3'd3,
    CFG_RATE   = 3'd4,
    CFG_LIMIT  = 3'd5,
    CFG_FLOOR  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_UPPER = 2'd1,
    CLAMP_DEAD  = 2'd2,
    CLAMP_LOWER = 2'd3
  } clamp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_STEP,
    ST_INTEG,
    ST_LOAD,
    ST_LO,
    ST_HI,
    ST_ACC,
    ST_ADD,
    ST_CLAMP
  } state_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

endpackage

>>> hdl/pidsc_mul.sv
// ----------------------------------------------------------------------------
// pidsc_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module pidsc_mul import pidsc_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

>>> hdl/pid_speed_controller_unit.sv
// ----------------------------------------------------------------------------
// pid_speed_controller_unit
// Fixed-point PID speed controller, one result per control tick.
// ----------------------------------------------------------------------------
// A tick is taken on in_* and its result appears on out_*; a new tick is taken
// only after the previous one leaves the clamp step. The schedule is set by
// one shared 33x25 multiplier that computes, in turn, the integral step, the
// derivative and the three gain products (each gain product as two 32-bit
// halves). A result waiting on out_* does not hold off the next tick; only
// the final clamp step waits for the output slot.
module pid_speed_controller_unit import pidsc_pkg::*; #(
  parameter int SPEED_FRAC_BITS = 16,
  parameter int INTEGRAL_WIDTH  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // [31:0] target_speed, [63:32] measured_speed
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] drive_voltage
  output logic [1:0]            out_tuser,  // [1:0] clamp_status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SHIFT = SPEED_FRAC_BITS + 4;
  localparam int IW    = INTEGRAL_WIDTH;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r, period_r;
  logic [RATE_W-1:0]  rate_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [VOLT_W-1:0]  floor_r;

  logic signed [SPEED_W-1:0] tgt_r, meas_r, err_r, prev_r;
  logic signed [SPEED_W:0]   dif_r;
  logic signed [IW-1:0]      integ_r;
  logic signed [DERIV_W-1:0] deriv_r;
  logic [TERM_W-1:0]         mag_r;
  logic                      neg_r;
  logic [ACC_W-1:0]          acc_r;
  logic signed [TERM_W-1:0]  v_r;
  term_t                     k_r;

  logic [VOLT_W-1:0] volt_r;
  clamp_t            stat_r;
  logic              out_tvalid_r;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_r;

  pidsc_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  logic in_xfer, out_free;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = volt_r;
  assign out_tuser  = stat_r;

  // error saturation
  logic signed [SPEED_W:0]   err_wide;
  logic signed [SPEED_W-1:0] err_sat;
  always_comb begin
    err_wide = {tgt_r[SPEED_W-1], tgt_r} - {meas_r[SPEED_W-1], meas_r};
    if (err_wide[SPEED_W] != err_wide[SPEED_W-1]) begin
      err_sat = err_wide[SPEED_W] ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
    end else begin
      err_sat = err_wide[SPEED_W-1:0];
    end
  end

  // integral update
  logic signed [SPEED_W-1:0] step;
  logic signed [IW:0]        isum;
  logic signed [IW-1:0]      integ_sat;
  always_comb begin
    step = prod_r[SPEED_W+23:24];
    isum = {integ_r[IW-1], integ_r} + {{(IW+1-SPEED_W){step[SPEED_W-1]}}, step};
    if (isum[IW] != isum[IW-1]) begin
      integ_sat = isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integ_sat = isum[IW-1:0];
    end
  end

  // term operand select and magnitude
  logic signed [TERM_W-1:0] op64;
  logic [GAIN_W-1:0]        gain;
  always_comb begin
    case (k_r)
      TERM_P:  op64 = {{(TERM_W-SPEED_W){err_r[SPEED_W-1]}}, err_r};
      TERM_I:  op64 = {{(TERM_W-IW){integ_r[IW-1]}}, integ_r};
      default: op64 = {{(TERM_W-DERIV_W){deriv_r[DERIV_W-1]}}, deriv_r};
    endcase
    case (k_r)
      TERM_P:  gain = kp_r;
      TERM_I:  gain = ki_r;
      default: gain = kd_r;
    endcase
  end

  // term reduce, sign and saturating sum
  logic [ACC_W-1:0]         shifted;
  logic [TERM_W-1:0]        r_mag;
  logic signed [TERM_W-1:0] term;
  logic signed [TERM_W:0]   vsum;
  logic signed [TERM_W-1:0] v_sat;
  always_comb begin
    shifted = acc_r >> SHIFT;
    r_mag   = (|shifted[ACC_W-1:TERM_W-1]) ? {1'b0, {(TERM_W-1){1'b1}}}
                                            : {1'b0, shifted[TERM_W-2:0]};
    term    = neg_r ? -$signed(r_mag) : $signed(r_mag);
    vsum    = {v_r[TERM_W-1], v_r} + {term[TERM_W-1], term};
    if (vsum[TERM_W] != vsum[TERM_W-1]) begin
      v_sat = vsum[TERM_W] ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
    end else begin
      v_sat = vsum[TERM_W-1:0];
    end
  end

  // output clamp
  logic signed [TERM_W-1:0] lim64, flo64;
  logic [VOLT_W-1:0]        volt_nxt;
  clamp_t                   stat_nxt;
  always_comb begin
    lim64 = {{(TERM_W-LIMIT_W){1'b0}}, limit_r};
    flo64 = {{(TERM_W-VOLT_W){floor_r[VOLT_W-1]}}, floor_r};
    if (v_r > lim64) begin
      volt_nxt = {1'b0, limit_r};
      stat_nxt = CLAMP_UPPER;
    end else if (v_r[TERM_W-1] && v_r > flo64) begin
      volt_nxt = '0;
      stat_nxt = CLAMP_DEAD;
    end else if (v_r < -lim64) begin
      volt_nxt = -{1'b0, limit_r};
      stat_nxt = CLAMP_LOWER;
    end else begin
      volt_nxt = v_r[VOLT_W-1:0];
      stat_nxt = CLAMP_NONE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_STEP;
      ST_STEP:  state_nxt = ST_INTEG;
      ST_INTEG: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_LO;
      ST_LO:    state_nxt = ST_HI;
      ST_HI:    state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_ADD;
      ST_ADD:   state_nxt = (k_r == TERM_D) ? ST_CLAMP : ST_LOAD;
      ST_CLAMP: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // multiplier control
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_STEP: begin
        mul_en = 1'b1;
        mul_a  = {err_r[SPEED_W-1], err_r};
        mul_b  = {1'b0, period_r};
      end
      ST_INTEG: begin
        mul_en = 1'b1;
        mul_a  = dif_r;
        mul_b  = {{(MUL_B_W-RATE_W){1'b0}}, rate_r};
      end
      ST_LO: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, mag_r[31:0]};
        mul_b  = {1'b0, gain};
      end
      ST_HI: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, mag_r[63:32]};
        mul_b  = {1'b0, gain};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      integ_r      <= '0;
      prev_r       <= '0;
      k_r          <= TERM_P;
      kp_r         <= KP_RST;
      ki_r         <= KI_RST;
      kd_r         <= KD_RST;
      period_r     <= PERIOD_RST;
      rate_r       <= RATE_RST;
      limit_r      <= LIMIT_RST;
      floor_r      <= FLOOR_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLAMP && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (state_r == ST_INTEG) begin
        integ_r <= integ_sat;
        prev_r  <= err_r;
        k_r     <= TERM_P;
      end
      if (state_r == ST_ADD) begin
        k_r <= term_t'(k_r + 2'd1);
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_KP:     kp_r     <= cfg_data;
          CFG_KI:     ki_r     <= cfg_data;
          CFG_KD:     kd_r     <= cfg_data;
          CFG_PERIOD: period_r <= cfg_data;
          CFG_RATE:   rate_r   <= cfg_data[RATE_W-1:0];
          CFG_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
          CFG_FLOOR:  floor_r  <= cfg_data[VOLT_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tgt_r  <= in_tdata[31:0];
      meas_r <= in_tdata[63:32];
    end
    case (state_r)
      ST_ERR:  err_r <= err_sat;
      ST_STEP: dif_r <= {err_r[SPEED_W-1], err_r} - {prev_r[SPEED_W-1], prev_r};
      ST_LOAD: begin
        if (k_r == TERM_P) begin
          deriv_r <= prod_r[DERIV_W-1:0];
          v_r     <= '0;
        end
        neg_r <= op64[TERM_W-1];
        mag_r <= op64[TERM_W-1] ? (~op64 + 64'd1) : op64;
      end
      ST_HI:   acc_r <= {{(ACC_W-56){1'b0}}, prod_r[55:0]};
      ST_ACC:  acc_r <= acc_r + {prod_r[55:0], 32'd0};
      ST_ADD:  v_r   <= v_sat;
      ST_CLAMP: begin
        if (out_free) begin
          volt_r <= volt_nxt;
          stat_r <= stat_nxt;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/pidsc_checker.sv
// ----------------------------------------------------------------------------
// pidsc_checker
// Port-level checks for the PID speed controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidsc_checker import pidsc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // one tick in flight at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a tick while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_upper_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CLAMP_UPPER |-> !out_tdata[15])
    else $error("upper clamp gave negative voltage");

  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CLAMP_DEAD |-> out_tdata == 16'd0)
    else $error("deadband result not zero");

  a_lower_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CLAMP_LOWER |-> out_tdata[15] || out_tdata == 16'd0)
    else $error("lower clamp gave positive voltage");

endmodule

bind pid_speed_controller_unit pidsc_checker u_pidsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/pid_speed_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// pid_speed_controller_unit_tb
// Self-checking bench for the PID speed controller. A scoreboard class keeps
// its own copy of the gains, the integral and the previous error. It predicts
// the drive voltage and the clamp status of every accepted tick and checks
// each result transfer against the oldest prediction. The stimulus starts
// with directed ticks at reset values and at register extremes. Random
// register settings and random ticks follow, with random gaps and stalls on
// both streams.
// ----------------------------------------------------------------------------
module pid_speed_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pidsc_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int INTEG_W       = 48;
  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int MAX_GAP       = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS   = 60;
  localparam int FILL_TICKS    = 12;

  localparam longint SAT_HI   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SAT_LO   = -SAT_HI - 1;
  localparam longint INT32_HI = 64'sd2147483647;
  localparam longint INT32_LO = -INT32_HI - 1;
  localparam longint INTEG_HI = (64'sd1 <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO = -INTEG_HI - 1;

  typedef struct {
    logic signed [VOLT_W-1:0] voltage;
    clamp_t                   status;
  } drive_t;

  class drive_scoreboard;
    logic [GAIN_W-1:0]  kp, ki, kd, period;
    logic [RATE_W-1:0]  rate;
    logic [LIMIT_W-1:0] limit;
    logic [VOLT_W-1:0]  dead_floor;
    longint             integ;
    longint             prev_err;
    drive_t             expected_drive[$];
    int                 mismatches;

    function new();
      kp = KP_RST;
      ki = KI_RST;
      kd = KD_RST;
      period = PERIOD_RST;
      rate = RATE_RST;
      limit = LIMIT_RST;
      dead_floor = FLOOR_RST;
      integ = 0;
      prev_err = 0;
      mismatches = 0;
    endfunction

    function void load_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_KP:     kp = d;
        CFG_KI:     ki = d;
        CFG_KD:     kd = d;
        CFG_PERIOD: period = d;
        CFG_RATE:   rate = d[RATE_W-1:0];
        CFG_LIMIT:  limit = d[LIMIT_W-1:0];
        CFG_FLOOR:  dead_floor = d[VOLT_W-1:0];
        default: ;
      endcase
    endfunction

    // gain * x with the gain taken as Q.20, truncated toward zero
    function longint gain_term(longint x, logic [GAIN_W-1:0] g);
      logic [127:0] mag, prod;
      mag = (x < 0) ? -x : x;
      prod = (mag * g) >> (FRAC_BITS + 4);
      if (prod > 128'(SAT_HI)) prod = 128'(SAT_HI);
      return (x < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = a + b;
      if (s > SAT_HI) return SAT_HI;
      if (s < SAT_LO) return SAT_LO;
      return s[63:0];
    endfunction

    function void take_tick(logic signed [SPEED_W-1:0] tgt,
                            logic signed [SPEED_W-1:0] meas);
      longint err, step, deriv, v, lim, flo;
      drive_t d;
      err = longint'(tgt) - longint'(meas);
      if (err > INT32_HI) err = INT32_HI;
      if (err < INT32_LO) err = INT32_LO;
      step = (err * longint'(period)) >>> 24;
      integ = integ + step;
      if (integ > INTEG_HI) integ = INTEG_HI;
      if (integ < INTEG_LO) integ = INTEG_LO;
      deriv = (err - prev_err) * longint'(rate);
      prev_err = err;
      v = gain_term(err, kp);
      v = add_sat(v, gain_term(integ, ki));
      v = add_sat(v, gain_term(deriv, kd));
      lim = longint'(limit);
      flo = longint'($signed(dead_floor));
      if (v > lim) begin
        d.voltage = lim[VOLT_W-1:0];
        d.status = CLAMP_UPPER;
      end else if (v < 0 && v > flo) begin
        d.voltage = '0;
        d.status = CLAMP_DEAD;
      end else if (v < -lim) begin
        d.voltage = 16'(-lim);
        d.status = CLAMP_LOWER;
      end else begin
        d.voltage = v[VOLT_W-1:0];
        d.status = CLAMP_NONE;
      end
      expected_drive.push_back(d);
    endfunction

    function void match_drive(logic signed [VOLT_W-1:0] voltage, logic [1:0] status);
      drive_t want;
      if (expected_drive.size() == 0) begin
        $error("drive_voltage %0d arrived with no tick outstanding", voltage);
        mismatches++;
        return;
      end
      want = expected_drive.pop_front();
      if (voltage !== want.voltage) begin
        $error("drive_voltage: expected %0d, got %0d", want.voltage, voltage);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("clamp_status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;   // [31:0] target_speed, [63:32] measured_speed
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // [15:0] drive_voltage
  logic [1:0]            out_tuser;  // [1:0] clamp_status
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drive_scoreboard sb = new();
  bit              no_gaps = 1'b0;
  bit              hold_out = 1'b0;
  logic [31:0]     held_err = '0;

  pid_speed_controller_unit #(
    .SPEED_FRAC_BITS(FRAC_BITS),
    .INTEGRAL_WIDTH(INTEG_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int next_gap();
    return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [31:0] corner_speed();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_value(logic [CFG_DATA_W-1:0] top);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return top;
      2, 3: return CFG_DATA_W'($urandom_range(0, top));
      default: return CFG_DATA_W'($urandom_range(0, top >> 8));
    endcase
  endfunction

  // in_tvalid stays high after a transfer; the next call lowers or reloads it
  task automatic send_tick(logic [31:0] tgt, logic [31:0] meas, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {meas, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_tick(tgt, meas);
  endtask

  task automatic random_tick(int gap);
    logic [31:0] tgt, meas, delta;
    case ($urandom_range(0, 9))
      0, 1: begin
        tgt = $urandom();
        meas = $urandom();
      end
      2, 3, 4, 5: begin
        tgt = $urandom();
        delta = $urandom_range(0, 262144) - 131072;
        meas = tgt - delta;
      end
      6, 7, 8: begin
        tgt = $urandom();
        meas = tgt - held_err;
      end
      default: begin
        tgt = corner_speed();
        meas = corner_speed();
      end
    endcase
    held_err = tgt - meas;
    send_tick(tgt, meas, gap);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.load_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic shuffle_cfg();
    write_cfg(CFG_KP, pick_value(24'hFF_FFFF));
    write_cfg(CFG_KI, pick_value(24'hFF_FFFF));
    write_cfg(CFG_KD, pick_value(24'hFF_FFFF));
    write_cfg(CFG_PERIOD, pick_value(24'hFF_FFFF));
    write_cfg(CFG_RATE, pick_value(24'h00_FFFF));
    write_cfg(CFG_LIMIT, pick_value(24'h00_7FFF));
    write_cfg(CFG_FLOOR, ($urandom_range(0, 7) == 0) ?
              24'($urandom()) : {8'h00, 16'(-$urandom_range(0, 32768))});
  endtask

  task automatic wait_all_drives();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_drive.size() != 0) @(posedge clk);
  endtask

  task automatic collect_results();
    int stall;
    forever begin
      if (hold_out) begin
        stall = HOLD_CYCLES;
        hold_out = 1'b0;
      end else begin
        stall = next_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.match_drive($signed(out_tdata), out_tuser);
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("pid_speed_controller_unit_tb NOT OK");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KP;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      collect_results();
    join_none

    // reset gains: zero, step, steady, saturated errors
    send_tick(32'h0000_0000, 32'h0000_0000, next_gap());
    send_tick(32'h0001_0000, 32'h0000_0000, next_gap());
    send_tick(32'h0001_0000, 32'h0000_0000, next_gap());
    send_tick(32'h0000_0000, 32'h0000_8000, next_gap());
    send_tick(32'h0000_0000, 32'h0000_8000, next_gap());
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, next_gap());
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, next_gap());
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, next_gap());
    send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, next_gap());
    send_tick(32'h8000_0000, 32'h8000_0000, next_gap());
    send_tick(32'hFFFF_FFFF, 32'h0000_0000, next_gap());
    send_tick(32'h0000_0000, 32'h0000_0000, next_gap());

    // full gains, zero period and rate, widest limit and floor
    wait_all_drives();
    write_cfg(CFG_KP, 24'hFF_FFFF);
    write_cfg(CFG_KI, 24'hFF_FFFF);
    write_cfg(CFG_KD, 24'hFF_FFFF);
    write_cfg(CFG_PERIOD, 24'h00_0000);
    write_cfg(CFG_RATE, 24'h00_0000);
    write_cfg(CFG_LIMIT, 24'hFF_FFFF);
    write_cfg(CFG_FLOOR, 24'h00_8000);
    send_tick(32'h0001_0000, 32'h0000_0000, next_gap());
    send_tick(32'h0001_0000, 32'h0000_0000, next_gap());
    send_tick(32'h0000_0000, 32'h0001_0000, next_gap());
    send_tick(32'hFFFF_FFFF, 32'h0000_0000, next_gap());

    // zero limit, positive floor: deadband never applies
    wait_all_drives();
    write_cfg(CFG_KP, 24'h00_0001);
    write_cfg(CFG_KI, 24'h00_0000);
    write_cfg(CFG_KD, 24'h00_0000);
    write_cfg(CFG_PERIOD, 24'hFF_FFFF);
    write_cfg(CFG_RATE, 24'h00_FFFF);
    write_cfg(CFG_LIMIT, 24'h00_0000);
    write_cfg(CFG_FLOOR, 24'h00_0001);
    send_tick(32'h0010_0000, 32'h0000_0000, next_gap());
    send_tick(32'h0000_0000, 32'h0010_0000, next_gap());
    send_tick(32'h0000_0000, 32'h0000_0000, next_gap());

    // floor below minus limit: deadband still wins
    wait_all_drives();
    write_cfg(CFG_KP, 24'h01_0000);
    write_cfg(CFG_PERIOD, 24'h00_0000);
    write_cfg(CFG_RATE, 24'h00_0000);
    write_cfg(CFG_LIMIT, 24'd100);
    write_cfg(CFG_FLOOR, 24'h00_8000);
    send_tick(32'h0000_0000, 32'h0000_4000, next_gap());
    send_tick(32'h0000_4000, 32'h0000_0000, next_gap());
    send_tick(32'h0000_0000, 32'h0100_0000, next_gap());
    send_tick(32'h0000_0000, 32'h0000_0000, next_gap());

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_all_drives();
      shuffle_cfg();
      no_gaps = (ph == 2);
      if (ph == 4) begin
        // stall the result side long enough to back up the input
        hold_out = 1'b1;
        for (int n = 0; n < FILL_TICKS; n++) random_tick(0);
        wait_all_drives();
      end
      for (int n = 0; n < PHASE_TICKS; n++) random_tick(next_gap());
    end
    no_gaps = 1'b0;

    wait_all_drives();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_drive.size() == 0)
      $display("pid_speed_controller_unit_tb OK");
    else
      $display("pid_speed_controller_unit_tb NOT OK");
    $finish;
  end

endmodule

>>> pid_speed_controller_unit.f
hdl/pidsc_pkg.sv
hdl/pidsc_mul.sv
hdl/pid_speed_controller_unit.sv
hdl/pidsc_checker.sv
tb/pid_speed_controller_unit_tb.sv
